[rtl/bmks_pkg.sv]
// Shared types and constants for the bit-packed multi-key equality scan.
// Holds the register index codes, queue entry layouts and back-end states.
// No dependencies; compiled before every other file of the block.
package bmks_pkg;

    // Fixed geometry of the scan
    localparam int WORD_BITS    = 32;
    localparam int LANES        = 32;   // elements per group, and max elements per word
    localparam int MAX_KEYS     = 4;
    localparam int LANE_CNT_W   = 6;    // holds 0..32 (and sums up to 63)
    localparam int WIDTH_BITS   = 6;
    localparam int KCNT_BITS    = 3;
    localparam int INDEX_BITS   = 19;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_W   = 32;
    localparam int MID_DEPTH    = 4;
    localparam int OUT_DEPTH    = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_WIDTH = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COUNT = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_KCNT  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_KEY_A = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_KEY_B = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_KEY_C = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_KEY_D = 3'd6;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [MAX_KEYS-1:0][WORD_BITS-1:0] bitmaps_t;

    // One classified word: per-key hit bits by lane, lane count, end flag
    typedef struct packed {
        logic [MAX_KEYS-1:0][LANES-1:0] match;
        logic [LANE_CNT_W-1:0]          lanes;
        logic                           last;
    } mid_entry_t;

    // One finished bitmap set
    typedef struct packed {
        bitmaps_t                bitmaps;
        logic [INDEX_BITS-1:0]   index;
        logic                    last;
    } result_t;

    typedef enum logic {
        BK_RUN,
        BK_FLUSH
    } back_state_t;

endpackage

[rtl/bmks_queue.sv]
// Small register-based FIFO used between the scan stages and at the output.
// Depends on nothing; width and depth come from parameters.
module bmks_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    // Occupancy never exceeds the depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue occupancy above depth");

    // Writers in this block only push when there is room
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("request pushed into full queue");

endmodule

[rtl/bmks_front.sv]
// Front end: unpacks one 32-bit word into up to 32 elements and compares
// each against the keys in use. Depends on bmks_pkg.
module bmks_front #(
    parameter int ACC_KEYS   = 4,
    parameter int COUNT_BITS = 24
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 take,
    input  bmks_pkg::word_t                      packed_word,
    input  logic                                 width_clear,
    input  logic [bmks_pkg::WIDTH_BITS-1:0]      element_width,
    input  logic [COUNT_BITS-1:0]                element_count,
    input  logic [bmks_pkg::KCNT_BITS-1:0]       key_count,
    input  bmks_pkg::bitmaps_t                   keys,
    output logic                                 entry_wr,
    output bmks_pkg::mid_entry_t                 entry
);
    import bmks_pkg::*;

    logic [WORD_BITS-1:0]   carry_reg;
    logic [WORD_BITS-1:0]   carry_next;
    logic [4:0]             cc_reg;
    logic [4:0]             cc_next;
    logic [COUNT_BITS-1:0]  seen_reg;
    logic [COUNT_BITS-1:0]  seen_next;

    logic [WIDTH_BITS-1:0]  w_eff;
    logic [KCNT_BITS-1:0]   nk_clip;
    logic [KCNT_BITS-1:0]   nk;
    logic [5:0]             avail;
    logic [63:0]            bits_w;
    logic [WORD_BITS-1:0]   emask;
    logic                   active;
    logic [COUNT_BITS-1:0]  rem;
    logic [LANE_CNT_W-1:0]  lanes;
    logic [11:0]            used;
    logic [5:0]             left;
    logic [63:0]            tail;
    logic                   last;

    wire  [LANES-1:0]                lane_ok;
    wire  [MAX_KEYS-1:0][LANES-1:0]  hit;

    // Effective width and key count
    assign w_eff   = (element_width == '0 || element_width > 6'd32) ? 6'd32 : element_width;
    assign nk_clip = (key_count > 3'd4) ? 3'd4 : key_count;
    assign nk      = (nk_clip > KCNT_BITS'(ACC_KEYS)) ? KCNT_BITS'(ACC_KEYS) : nk_clip;

    // Bit buffer: carried bits below the new word
    assign avail  = {1'b1, cc_reg};
    assign bits_w = {32'd0, carry_reg} | ({32'd0, packed_word} << cc_reg);
    assign emask  = (w_eff == 6'd32) ? '1 : 32'((33'd1 << w_eff) - 33'd1);

    assign active = (seen_reg < element_count);
    assign rem    = element_count - seen_reg;

    // Per-lane extraction and key compare
    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        logic [10:0]          start;
        logic [10:0]          stop;
        logic [63:0]          shifted;
        logic [WORD_BITS-1:0] elem;

        assign start   = 11'(i) * {5'd0, w_eff};
        assign stop    = start + {5'd0, w_eff};
        assign shifted = bits_w >> start[5:0];
        assign elem    = shifted[WORD_BITS-1:0] & emask;
        assign lane_ok[i] = (stop <= {5'd0, avail}) && (rem > COUNT_BITS'(i));

        for (genvar k = 0; k < MAX_KEYS; k++)
        begin : g_key
            if (k < ACC_KEYS)
            begin : g_used
                assign hit[k][i] = lane_ok[i] && (KCNT_BITS'(k) < nk) && (elem == keys[k]);
            end
            else
            begin : g_unused
                assign hit[k][i] = 1'b0;
            end
        end
    end

    // Valid lanes form a prefix; count them
    always_comb
    begin
        lanes = '0;
        for (int i = 0; i < LANES; i++)
        begin
            if (lane_ok[i])
            begin
                lanes = LANE_CNT_W'(i + 1);
            end
        end
    end

    // Consumed bits and leftover for the next word
    assign used = {6'd0, lanes} * {6'd0, w_eff};
    assign left = avail - used[5:0];
    assign tail = bits_w >> used[5:0];
    assign last = (rem == COUNT_BITS'(lanes));

    assign entry_wr    = take && active;
    assign entry.match = hit;
    assign entry.lanes = lanes;
    assign entry.last  = last;

    // State update
    always_comb
    begin
        carry_next = carry_reg;
        cc_next    = cc_reg;
        seen_next  = seen_reg;
        if (width_clear)
        begin
            carry_next = '0;
            cc_next    = '0;
        end
        else if (entry_wr)
        begin
            seen_next = seen_reg + COUNT_BITS'(lanes);
            if (last)
            begin
                carry_next = '0;
                cc_next    = '0;
            end
            else
            begin
                carry_next = tail[WORD_BITS-1:0];
                cc_next    = left[4:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carry_reg <= '0;
            cc_reg    <= '0;
            seen_reg  <= '0;
        end
        else
        begin
            carry_reg <= carry_next;
            cc_reg    <= cc_next;
            seen_reg  <= seen_next;
        end
    end

    // A word that is scanned always yields at least one element
    a_lanes_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        entry_wr |-> (entry.lanes != '0))
        else $error("scanned word produced no elements");

endmodule

[rtl/bmks_back.sv]
// Back end: merges classified hit vectors into the per-key group bitmaps
// and emits a bitmap set per full group or at end of scan. Uses bmks_pkg.
module bmks_back #(
    parameter int ACC_KEYS = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bmks_pkg::mid_entry_t  entry,
    input  logic                  entry_empty,
    output logic                  entry_pop,
    input  logic                  res_full,
    output logic                  res_push,
    output bmks_pkg::result_t     res
);
    import bmks_pkg::*;

    back_state_t                          state_reg;
    back_state_t                          state_next;
    logic [ACC_KEYS-1:0][WORD_BITS-1:0]   acc_reg;
    logic [ACC_KEYS-1:0][WORD_BITS-1:0]   acc_next;
    logic [4:0]                           gp_reg;
    logic [4:0]                           gp_next;
    logic [INDEX_BITS-1:0]                gc_reg;
    logic [INDEX_BITS-1:0]                gc_next;

    logic [5:0]                           sum;
    logic                                 grp_done;
    logic                                 split_end;
    logic                                 can_go;
    logic [ACC_KEYS-1:0][WORD_BITS-1:0]   cur;
    logic [ACC_KEYS-1:0][WORD_BITS-1:0]   spill;
    logic [ACC_KEYS-1:0][WORD_BITS-1:0]   res_acc;
    logic [63:0]                          shifted;

    assign sum       = {1'b0, gp_reg} + entry.lanes;
    assign grp_done  = sum[5];
    assign split_end = grp_done && entry.last && (sum != 6'd32);
    assign can_go    = !res_full;

    // Place the hit lanes at the current group position
    always_comb
    begin
        shifted = '0;
        for (int k = 0; k < ACC_KEYS; k++)
        begin
            shifted  = {32'd0, entry.match[k]} << gp_reg;
            cur[k]   = acc_reg[k] | shifted[WORD_BITS-1:0];
            spill[k] = shifted[63:32];
        end
    end

    // Next state: a word that completes a group and then ends the scan
    // goes to the flush state to emit the final partial group
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_RUN:
            begin
                if (can_go && !entry_empty && split_end)
                begin
                    state_next = BK_FLUSH;
                end
            end
            BK_FLUSH:
            begin
                if (can_go)
                begin
                    state_next = BK_RUN;
                end
            end
            default: state_next = BK_RUN;
        endcase
    end

    // Datapath and handshake outputs
    always_comb
    begin
        entry_pop = 1'b0;
        res_push  = 1'b0;
        acc_next  = acc_reg;
        gp_next   = gp_reg;
        gc_next   = gc_reg;
        res_acc   = cur;
        res.last  = 1'b0;
        case (state_reg)
            BK_FLUSH:
            begin
                res_acc  = acc_reg;
                res.last = 1'b1;
                if (can_go)
                begin
                    res_push = 1'b1;
                    acc_next = '0;
                    gp_next  = '0;
                    gc_next  = gc_reg + 1'b1;
                end
            end
            BK_RUN:
            begin
                res_acc  = cur;
                res.last = entry.last && !split_end;
                if (can_go && !entry_empty)
                begin
                    entry_pop = 1'b1;
                    if (grp_done || entry.last)
                    begin
                        res_push = 1'b1;
                        gc_next  = gc_reg + 1'b1;
                    end
                    if (entry.last && !split_end)
                    begin
                        acc_next = '0;
                        gp_next  = '0;
                    end
                    else if (grp_done)
                    begin
                        acc_next = spill;
                        gp_next  = sum[4:0];
                    end
                    else
                    begin
                        acc_next = cur;
                        gp_next  = sum[4:0];
                    end
                end
            end
            default:
            begin
                res_acc = cur;
            end
        endcase
        res.bitmaps = '0;
        for (int k = 0; k < ACC_KEYS; k++)
        begin
            res.bitmaps[k] = res_acc[k];
        end
        res.index = gc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_RUN;
            acc_reg   <= '0;
            gp_reg    <= '0;
            gc_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            acc_reg   <= acc_next;
            gp_reg    <= gp_next;
            gc_reg    <= gc_next;
        end
    end

    // The flush state is only entered from a word that ends the scan
    a_flush_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_FLUSH && $past(state_reg) == BK_RUN)
            |-> $past(entry_pop && entry.last))
        else $error("flush entered without end of scan");

    // After the last set of a column the group restarts at position zero
    a_end_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res.last) |=> (gp_reg == '0 && state_reg == BK_RUN))
        else $error("group not restarted after end of scan");

    // Nothing is emitted while the output queue is full
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> (!res_full && (entry_pop || state_reg == BK_FLUSH)))
        else $error("result emitted without a source or without room");

endmodule

[rtl/bitpacked_multi_key_equality_scan_core.sv]
// Path: an accepted word is unpacked and compared combinationally, then written to the
// middle queue; the back end merges it into a set in the result queue, which feeds the
// outputs. Throughput: one packed word per cycle while full is low; a word that both
// completes a group and ends the column has its second set sent from the flush state.
// Buffering: 4-entry queue between front and back end, 2-entry result queue.
// Reset (async, active low): state, queues cleared; width 8, count 1, one key, keys zero.
module bitpacked_multi_key_equality_scan_core #(
    parameter int NUM_KEYS   = 4,
    parameter int COUNT_BITS = 24
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // input word queue side
    input  logic                                   push,
    output logic                                   full,
    input  logic [bmks_pkg::WORD_BITS-1:0]         packed_word,
    // result queue side
    output logic                                   empty,
    input  logic                                   pop,
    output logic [bmks_pkg::WORD_BITS-1:0]         bitmap_a,
    output logic [bmks_pkg::WORD_BITS-1:0]         bitmap_b,
    output logic [bmks_pkg::WORD_BITS-1:0]         bitmap_c,
    output logic [bmks_pkg::WORD_BITS-1:0]         bitmap_d,
    output logic [bmks_pkg::INDEX_BITS-1:0]        bitmap_index,
    output logic                                   end_of_scan,
    // register write port
    input  logic                                   cfg_wen,
    input  logic [bmks_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [bmks_pkg::CFG_DATA_W-1:0]        cfg_wdata
);
    import bmks_pkg::*;

    localparam int ACC_KEYS = (NUM_KEYS < MAX_KEYS) ? NUM_KEYS : MAX_KEYS;

    logic [WIDTH_BITS-1:0]  width_reg;
    logic [WIDTH_BITS-1:0]  width_next;
    logic [COUNT_BITS-1:0]  count_reg;
    logic [COUNT_BITS-1:0]  count_next;
    logic [KCNT_BITS-1:0]   kcnt_reg;
    logic [KCNT_BITS-1:0]   kcnt_next;
    bitmaps_t               keys_reg;
    bitmaps_t               keys_next;
    logic                   width_clear;

    logic                   take;
    logic                   mid_wr;
    mid_entry_t             mid_wdata;
    mid_entry_t             mid_rdata;
    logic                   mid_empty;
    logic                   mid_pop;
    logic                   res_push;
    logic                   res_full;
    result_t                res_wdata;
    result_t                res_head;

    // Register writes
    always_comb
    begin
        width_next = width_reg;
        count_next = count_reg;
        kcnt_next  = kcnt_reg;
        keys_next  = keys_reg;
        if (cfg_wen)
        begin
            case (cfg_index)
                CFG_WIDTH: width_next   = cfg_wdata[WIDTH_BITS-1:0];
                CFG_COUNT: count_next   = cfg_wdata[COUNT_BITS-1:0];
                CFG_KCNT:  kcnt_next    = cfg_wdata[KCNT_BITS-1:0];
                CFG_KEY_A: keys_next[0] = cfg_wdata;
                CFG_KEY_B: keys_next[1] = cfg_wdata;
                CFG_KEY_C: keys_next[2] = cfg_wdata;
                CFG_KEY_D: keys_next[3] = cfg_wdata;
                default:   width_next   = width_reg;
            endcase
        end
    end

    assign width_clear = cfg_wen && (cfg_index == CFG_WIDTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= WIDTH_BITS'(8);
            count_reg <= COUNT_BITS'(1);
            kcnt_reg  <= KCNT_BITS'(1);
            keys_reg  <= '0;
        end
        else
        begin
            width_reg <= width_next;
            count_reg <= count_next;
            kcnt_reg  <= kcnt_next;
            keys_reg  <= keys_next;
        end
    end

    // Front end: unpack and compare
    assign take = push && !full;

    bmks_front #(
        .ACC_KEYS   (ACC_KEYS),
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (take),
        .packed_word   (packed_word),
        .width_clear   (width_clear),
        .element_width (width_reg),
        .element_count (count_reg),
        .key_count     (kcnt_reg),
        .keys          (keys_reg),
        .entry_wr      (mid_wr),
        .entry         (mid_wdata)
    );

    // Decoupling queue between front and back end
    bmks_queue #(
        .WIDTH ($bits(mid_entry_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mid_wr),
        .wdata (mid_wdata),
        .full  (full),
        .pop   (mid_pop),
        .rdata (mid_rdata),
        .empty (mid_empty)
    );

    // Back end: group assembly
    bmks_back #(
        .ACC_KEYS (ACC_KEYS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .entry       (mid_rdata),
        .entry_empty (mid_empty),
        .entry_pop   (mid_pop),
        .res_full    (res_full),
        .res_push    (res_push),
        .res         (res_wdata)
    );

    // Result queue toward the consumer
    bmks_queue #(
        .WIDTH ($bits(result_t)),
        .DEPTH (OUT_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_wdata),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_head),
        .empty (empty)
    );

    assign bitmap_a     = res_head.bitmaps[0];
    assign bitmap_b     = res_head.bitmaps[1];
    assign bitmap_c     = res_head.bitmaps[2];
    assign bitmap_d     = res_head.bitmaps[3];
    assign bitmap_index = res_head.index;
    assign end_of_scan  = res_head.last;

endmodule
